FILE: src/hsmt_pkg.sv
// ----------------------------------------------------------------------------
// hsmt_pkg
// Shared types, codes and constants for the health score / mode tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsmt_pkg;

  localparam int SCORE_W = 7;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEALTHY_THR      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UI_THR           = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_THR          = 2'd3;

  // operation codes
  localparam logic [1:0] OP_FAULT    = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_SET_MODE = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  // mode codes
  localparam logic [1:0] MODE_NORMAL       = 2'd0;
  localparam logic [1:0] MODE_DEGRADED_UI  = 2'd1;
  localparam logic [1:0] MODE_DEGRADED_NET = 2'd2;
  localparam logic [1:0] MODE_SAFE         = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] penalty;
    logic       is_stall;
    logic       is_memory;
    logic       is_network;
    logic [7:0] fault_id;
    logic [1:0] forced_mode;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  health_score;
    logic [6:0]  memory_score;
    logic [6:0]  network_score;
    logic [1:0]  mode;
    logic        healthy;
    logic [31:0] stall_total;
    logic [31:0] uptime_ticks;
    logic [7:0]  last_fault_id;
  } out_item_t;

  // classified command handed from the front to the back
  typedef struct packed {
    logic               do_fault;
    logic               do_tick;
    logic               do_set;
    logic               stall_inc;
    logic               mem_hit;
    logic               net_hit;
    logic [SCORE_W-1:0] penalty;
    logic [7:0]         fault_id;
    logic [1:0]         forced_mode;
  } cmd_t;

endpackage

FILE: src/health_score_mode_tracker.sv
// ----------------------------------------------------------------------------
// health_score_mode_tracker
// An accepted transaction is written into the command queue; the back end takes it from there
// and registers its result in the output register, where the receiver takes it.
// Throughput: one transaction per cycle while the receiver keeps out_ready high.
// A two-entry command queue lets input and output stall independently.
// Reset (rst_n low, synchronous): scores to 100, mode normal, counters and fault id to 0,
// configuration registers to 60 / 80 / 60 / 40, queue and output register empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module health_score_mode_tracker import hsmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  hsmt_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  hsmt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  hsmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/hsmt_front.sv
// ----------------------------------------------------------------------------
// hsmt_front
// Decodes an incoming transaction into a command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsmt_front import hsmt_pkg::*; (
  input  in_item_t item,
  output cmd_t     cmd
);

  always_comb begin
    cmd = '0;
    unique case (item.operation)
      OP_FAULT: begin
        cmd.do_fault  = 1'b1;
        cmd.stall_inc = item.is_stall;
        cmd.mem_hit   = item.is_memory;
        cmd.net_hit   = item.is_network;
      end
      OP_TICK:     cmd.do_tick = 1'b1;
      OP_SET_MODE: cmd.do_set  = 1'b1;
      OP_QUERY:    cmd.do_set  = 1'b0;
      default:     cmd.do_set  = 1'b0;
    endcase
    // scores never exceed 127, so any larger penalty drains them to zero
    cmd.penalty     = item.penalty[7] ? {SCORE_W{1'b1}} : item.penalty[SCORE_W-1:0];
    cmd.fault_id    = item.fault_id;
    cmd.forced_mode = item.forced_mode;
  end

endmodule

FILE: src/hsmt_queue.sv
// ----------------------------------------------------------------------------
// hsmt_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsmt_queue import hsmt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: src/hsmt_back.sv
// ----------------------------------------------------------------------------
// hsmt_back
// Executes commands against the health state and registers each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsmt_back import hsmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  logic [15:0]        interval_r;
  logic [SCORE_W-1:0] healthy_thr_r, ui_thr_r, net_thr_r;

  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [SCORE_W-1:0] mem_r, mem_nxt;
  logic [SCORE_W-1:0] net_r, net_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [31:0]        stall_r, stall_nxt;
  logic [31:0]        uptime_r, uptime_nxt;
  logic [15:0]        rticks_r, rticks_nxt;
  logic [7:0]         fault_r, fault_nxt;

  logic               out_valid_r;
  out_item_t          out_data_r;
  logic               take;
  logic [15:0]        rticks_inc;
  logic [SCORE_W-1:0] score_up;

  assign cmd_ready = !out_valid_r || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r    <= 16'd60;
      healthy_thr_r <= 7'd80;
      ui_thr_r      <= 7'd60;
      net_thr_r     <= 7'd40;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RECOVER_INTERVAL: interval_r    <= cfg_wdata;
        CFG_HEALTHY_THR:      healthy_thr_r <= cfg_wdata[SCORE_W-1:0];
        CFG_UI_THR:           ui_thr_r      <= cfg_wdata[SCORE_W-1:0];
        CFG_NET_THR:          net_thr_r     <= cfg_wdata[SCORE_W-1:0];
        default:              interval_r    <= interval_r;
      endcase
    end
  end

  always_comb begin
    score_nxt  = score_r;
    mem_nxt    = mem_r;
    net_nxt    = net_r;
    mode_nxt   = mode_r;
    stall_nxt  = stall_r;
    uptime_nxt = uptime_r;
    rticks_nxt = rticks_r;
    fault_nxt  = fault_r;
    rticks_inc = (rticks_r != 16'hFFFF) ? rticks_r + 16'd1 : rticks_r;
    score_up   = score_r + 7'd1;

    if (cmd.do_fault) begin
      score_nxt = (score_r > cmd.penalty) ? score_r - cmd.penalty : '0;
      if (cmd.stall_inc) stall_nxt = stall_r + 32'd1;
      if (cmd.mem_hit)   mem_nxt = (mem_r > cmd.penalty) ? mem_r - cmd.penalty : '0;
      if (cmd.net_hit)   net_nxt = (net_r > cmd.penalty) ? net_r - cmd.penalty : '0;
      fault_nxt = cmd.fault_id;
      // drop the mode by the first threshold the new score falls under
      if (score_nxt < net_thr_r)          mode_nxt = MODE_SAFE;
      else if (score_nxt < ui_thr_r)      mode_nxt = MODE_DEGRADED_NET;
      else if (score_nxt < healthy_thr_r) mode_nxt = MODE_DEGRADED_UI;
    end else if (cmd.do_tick) begin
      if (uptime_r != 32'hFFFF_FFFF) uptime_nxt = uptime_r + 32'd1;
      rticks_nxt = rticks_inc;
      if (rticks_inc >= interval_r) begin
        rticks_nxt = '0;
        if (score_r < SCORE_MAX) begin
          score_nxt = score_up;
          if (score_up >= healthy_thr_r) begin
            mode_nxt  = MODE_NORMAL;
            fault_nxt = '0;
          end else if (score_up >= ui_thr_r) begin
            mode_nxt = MODE_DEGRADED_UI;
          end else if (score_up >= net_thr_r) begin
            mode_nxt = MODE_DEGRADED_NET;
          end
        end
        if (mem_r < SCORE_MAX) mem_nxt = mem_r + 7'd1;
        if (net_r < SCORE_MAX) net_nxt = net_r + 7'd1;
      end
    end else if (cmd.do_set) begin
      mode_nxt = cmd.forced_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r     <= SCORE_MAX;
      mem_r       <= SCORE_MAX;
      net_r       <= SCORE_MAX;
      mode_r      <= MODE_NORMAL;
      stall_r     <= '0;
      uptime_r    <= '0;
      rticks_r    <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        score_r  <= score_nxt;
        mem_r    <= mem_nxt;
        net_r    <= net_nxt;
        mode_r   <= mode_nxt;
        stall_r  <= stall_nxt;
        uptime_r <= uptime_nxt;
        rticks_r <= rticks_nxt;
        fault_r  <= fault_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.health_score  <= score_nxt;
      out_data_r.memory_score  <= mem_nxt;
      out_data_r.network_score <= net_nxt;
      out_data_r.mode          <= mode_nxt;
      out_data_r.healthy       <= (score_nxt >= healthy_thr_r);
      out_data_r.stall_total   <= stall_nxt;
      out_data_r.uptime_ticks  <= uptime_nxt;
      out_data_r.last_fault_id <= fault_nxt;
    end
  end

endmodule

FILE: sim/health_score_mode_tracker_tb.sv
// ----------------------------------------------------------------------------
// health_score_mode_tracker_tb
// Self-checking bench for the health score / degradation mode tracker. A
// driver feeds faults, ticks, mode overrides and queries from a queue. A
// scoreboard model predicts scores, mode, counters and fault id per item, and
// a monitor compares every status transaction field by field. Settings of the
// recovery interval and thresholds are changed while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module health_score_mode_tracker_tb;
  import hsmt_pkg::*;

  localparam int SEGMENT_ITEMS = 125;
  localparam int SEGMENTS      = 12;
  localparam int DRAIN_CYCLES  = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RECOVER_INTERVAL;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  health_score_mode_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the tracker state and its settings
  logic [15:0] interval_r   = 16'd60;
  logic [6:0]  healthy_thr_r = 7'd80;
  logic [6:0]  ui_thr_r      = 7'd60;
  logic [6:0]  net_thr_r     = 7'd40;
  logic [6:0]  score_r      = SCORE_MAX;
  logic [6:0]  mem_score_r  = SCORE_MAX;
  logic [6:0]  net_score_r  = SCORE_MAX;
  logic [1:0]  mode_r       = MODE_NORMAL;
  logic [31:0] stalls_r     = '0;
  logic [31:0] uptime_r     = '0;
  logic [15:0] rec_ticks_r  = '0;
  logic [7:0]  fault_id_r   = '0;

  in_item_t  pending_items[$];
  out_item_t expected_status_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int n_faults = 0, n_ticks = 0, n_sets = 0, n_queries = 0;
  int n_recoveries = 0, n_checked = 0, n_settings = 0;

  task automatic track_health(input in_item_t it);
    out_item_t status;
    begin
      case (it.operation)
        OP_FAULT: begin
          n_faults++;
          score_r = (score_r > it.penalty) ? score_r - it.penalty : '0;
          if (it.is_stall) stalls_r = stalls_r + 32'd1;
          if (it.is_memory)
            mem_score_r = (mem_score_r > it.penalty) ? mem_score_r - it.penalty : '0;
          if (it.is_network)
            net_score_r = (net_score_r > it.penalty) ? net_score_r - it.penalty : '0;
          fault_id_r = it.fault_id;
          if (score_r < net_thr_r) mode_r = MODE_SAFE;
          else if (score_r < ui_thr_r) mode_r = MODE_DEGRADED_NET;
          else if (score_r < healthy_thr_r) mode_r = MODE_DEGRADED_UI;
        end
        OP_TICK: begin
          n_ticks++;
          if (uptime_r != 32'hFFFF_FFFF) uptime_r = uptime_r + 32'd1;
          if (rec_ticks_r != 16'hFFFF) rec_ticks_r = rec_ticks_r + 16'd1;
          if (rec_ticks_r >= interval_r) begin
            n_recoveries++;
            rec_ticks_r = '0;
            if (score_r < SCORE_MAX) begin
              score_r = score_r + 7'd1;
              if (score_r >= healthy_thr_r) begin
                mode_r = MODE_NORMAL;
                fault_id_r = '0;
              end else if (score_r >= ui_thr_r) begin
                mode_r = MODE_DEGRADED_UI;
              end else if (score_r >= net_thr_r) begin
                mode_r = MODE_DEGRADED_NET;
              end
            end
            if (mem_score_r < SCORE_MAX) mem_score_r = mem_score_r + 7'd1;
            if (net_score_r < SCORE_MAX) net_score_r = net_score_r + 7'd1;
          end
        end
        OP_SET_MODE: begin
          n_sets++;
          mode_r = it.forced_mode;
        end
        default: n_queries++;
      endcase
      status.health_score  = score_r;
      status.memory_score  = mem_score_r;
      status.network_score = net_score_r;
      status.mode          = mode_r;
      status.healthy       = (score_r >= healthy_thr_r);
      status.stall_total   = stalls_r;
      status.uptime_ticks  = uptime_r;
      status.last_fault_id = fault_id_r;
      expected_status_q.push_back(status);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    begin
      if (want !== got) begin
        mismatch_count++;
        $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
      end
    end
  endtask

  // driver: predict on acceptance, then load the next transaction or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_health(in_data);
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each status transaction against the oldest prediction
  always @(posedge clk) begin : monitor_proc
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: status with nothing expected, got %p", $time, out_data);
        end else begin
          want = expected_status_q.pop_front();
          n_checked++;
          check_field("health_score", 32'(want.health_score), 32'(out_data.health_score));
          check_field("memory_score", 32'(want.memory_score), 32'(out_data.memory_score));
          check_field("network_score", 32'(want.network_score),
                      32'(out_data.network_score));
          check_field("mode", 32'(want.mode), 32'(out_data.mode));
          check_field("healthy", 32'(want.healthy), 32'(out_data.healthy));
          check_field("stall_total", want.stall_total, out_data.stall_total);
          check_field("uptime_ticks", want.uptime_ticks, out_data.uptime_ticks);
          check_field("last_fault_id", 32'(want.last_fault_id),
                      32'(out_data.last_fault_id));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t make_item(input logic [1:0] op, input logic [7:0] pen,
                                         input logic st, input logic mem,
                                         input logic net, input logic [7:0] id,
                                         input logic [1:0] fm);
    in_item_t it;
    it.operation   = op;
    it.penalty     = pen;
    it.is_stall    = st;
    it.is_memory   = mem;
    it.is_network  = net;
    it.fault_id    = id;
    it.forced_mode = fm;
    return it;
  endfunction

  function automatic in_item_t random_item();
    logic [31:0] raw;
    in_item_t it;
    int unsigned pick;
    raw  = $urandom;
    it   = in_item_t'(raw[$bits(in_item_t)-1:0]);
    pick = $urandom_range(99);
    if (pick < 15) it.operation = OP_FAULT;
    else if (pick < 75) it.operation = OP_TICK;
    else if (pick < 87) it.operation = OP_SET_MODE;
    else it.operation = OP_QUERY;
    // keep most penalties small so scores hover around the thresholds
    if ($urandom_range(19) != 0) it.penalty = 8'($urandom_range(8));
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= val;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      case (idx)
        CFG_RECOVER_INTERVAL: interval_r = val;
        CFG_HEALTHY_THR:      healthy_thr_r = val[6:0];
        CFG_UI_THR:           ui_thr_r = val[6:0];
        default:              net_thr_r = val[6:0];
      endcase
    end
  endtask

  task automatic apply_setting(input logic [15:0] interval, input logic [6:0] hthr,
                               input logic [6:0] uthr, input logic [6:0] nthr);
    begin
      write_reg(CFG_RECOVER_INTERVAL, interval);
      write_reg(CFG_HEALTHY_THR, {9'd0, hthr});
      write_reg(CFG_UI_THR, {9'd0, uthr});
      write_reg(CFG_NET_THR, {9'd0, nthr});
      n_settings++;
    end
  endtask

  // hold until the queue is drained and every status has come back
  task automatic wait_idle();
    begin
      do @(negedge clk);
      while (pending_items.size() != 0 || in_valid || expected_status_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
  endtask

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, threshold crossings, saturation, all overrides
    send_idle_pct = 6;
    recv_idle_pct = 75;
    write_reg(CFG_RECOVER_INTERVAL, 16'd2);
    @(negedge clk);
    pending_items.push_back(make_item(OP_QUERY, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, MODE_NORMAL));
    pending_items.push_back(make_item(OP_FAULT, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, MODE_NORMAL));
    pending_items.push_back(make_item(OP_FAULT, 8'd15, 1'b1, 1'b1, 1'b0, 8'h01, MODE_SAFE));
    pending_items.push_back(make_item(OP_FAULT, 8'd10, 1'b0, 1'b0, 1'b1, 8'hFF, MODE_NORMAL));
    pending_items.push_back(make_item(OP_FAULT, 8'd20, 1'b1, 1'b0, 1'b0, 8'h5A, MODE_NORMAL));
    pending_items.push_back(make_item(OP_FAULT, 8'd20, 1'b0, 1'b1, 1'b1, 8'hA5, MODE_NORMAL));
    pending_items.push_back(make_item(OP_FAULT, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h80, MODE_NORMAL));
    pending_items.push_back(make_item(OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, MODE_SAFE));
    pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, MODE_NORMAL));
    pending_items.push_back(make_item(OP_SET_MODE, 8'h3C, 1'b1, 1'b0, 1'b1, 8'h11,
                                      MODE_NORMAL));
    pending_items.push_back(make_item(OP_SET_MODE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00,
                                      MODE_DEGRADED_UI));
    pending_items.push_back(make_item(OP_SET_MODE, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF,
                                      MODE_DEGRADED_NET));
    pending_items.push_back(make_item(OP_SET_MODE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, MODE_SAFE));
    pending_items.push_back(make_item(OP_FAULT, 8'h80, 1'b0, 1'b1, 1'b0, 8'h7F, MODE_SAFE));
    repeat (4)
      pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, MODE_NORMAL));
    pending_items.push_back(make_item(OP_QUERY, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, MODE_SAFE));
    wait_idle();

    // random: a new setting per segment, idling pattern changes every four
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0: begin send_idle_pct = 6;  recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (seg)
        0: apply_setting(16'd1, 7'd80, 7'd60, 7'd40);
        1: apply_setting(16'd0, 7'd100, 7'd50, 7'd20);
        2: apply_setting(16'd3, 7'd0, 7'd0, 7'd0);
        3: apply_setting(16'd1, 7'd127, 7'd127, 7'd127);
        4: apply_setting(16'hFFFF, 7'd80, 7'd60, 7'd40);
        5: apply_setting(16'd2, 7'd30, 7'd60, 7'd90);
        6: apply_setting(16'd1, 7'd50, 7'd50, 7'd50);
        default: apply_setting(16'($urandom_range(5)), 7'($urandom_range(127)),
                               7'($urandom_range(127)), 7'($urandom_range(127)));
      endcase
      @(negedge clk);
      repeat (SEGMENT_ITEMS) pending_items.push_back(random_item());
      wait_idle();
    end

    $display("covered %0d faults, %0d ticks (%0d recoveries), %0d mode overrides, %0d queries",
             n_faults, n_ticks, n_recoveries, n_sets, n_queries);
    $display("checked %0d status transactions under %0d register settings",
             n_checked, n_settings);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/hsmt_pkg.sv
src/hsmt_front.sv
src/hsmt_queue.sv
src/hsmt_back.sv
src/health_score_mode_tracker.sv
sim/health_score_mode_tracker_tb.sv
